>>> rtl/core/wst_pkg.sv
// Package for the wheel speed tracker core: widths, register indexes, constants.
// No dependencies.
package wst_pkg;
  localparam int unsigned DIAM_W   = 13;
  localparam int unsigned TPR_W    = 8;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned UM_PER_CI = 798;
  localparam int unsigned MIN_TPR_ACCEL = 6;
  localparam int unsigned DIV_W    = 64;

  localparam logic [1:0] REG_DIAM = 2'd0;
  localparam logic [1:0] REG_TPR  = 2'd1;
  localparam logic [1:0] REG_THR  = 2'd2;

  typedef struct packed {
    logic [31:0] pulse_count;
    logic [31:0] distance_m;
    logic [15:0] speed_mm_s;
    logic signed [15:0] accel_mm_s2;
    logic        rising_edge;
    logic        debounced_level;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
  } div_req_t;
endpackage

>>> rtl/core/wst_if.sv
// Valid/ready channel interfaces for the tracker core.
// No dependencies.
interface wst_in_if;
  logic valid;
  logic ready;
  logic sensor_level;
  modport source (output valid, output sensor_level, input ready);
  modport sink (input valid, input sensor_level, output ready);
endinterface

interface wst_out_if;
  logic valid;
  logic ready;
  logic [31:0] pulse_count;
  logic [31:0] distance_m;
  logic [15:0] speed_mm_s;
  logic signed [15:0] accel_mm_s2;
  logic rising_edge;
  logic debounced_level;
  modport source (output valid, output pulse_count, output distance_m, output speed_mm_s,
                  output accel_mm_s2, output rising_edge, output debounced_level,
                  input ready);
  modport sink (input valid, input pulse_count, input distance_m, input speed_mm_s,
                input accel_mm_s2, input rising_edge, input debounced_level,
                output ready);
endinterface

>>> rtl/core/wst_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on wst_pkg.
module wst_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wst_pkg::div_req_t         req,
  output logic                      done,
  output logic [wst_pkg::DIV_W-1:0] quo
);
  localparam int W = wst_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, q_r[W-1]} - {1'b0, den_r};
    if (req.start) begin
      q_nxt = req.num;
      rem_nxt = '0;
      den_nxt = req.den;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

>>> rtl/core/wheel_speed_sensor_tracker_core.sv
// Wheel speed tracker core: debounce, interval history, distance/speed/accel.
// Depends on wst_pkg, wst_if, wst_div. Up to 13 divisions share one 64-step divider.
// Divisions on zero intervals are skipped, accel with ticks_per_rotation below 6, all with it zero.
// One word at a time: ready is low while busy; the next word is accepted in the cycle after the
// result is loaded, and a result still waiting holds the sequencer at its end. Sync reset sets
// config to defaults and clears tracker, sequencer and output-valid state, not the datapath.
module wheel_speed_sensor_tracker_core #(
  parameter int TICK_RATE_HZ  = 10000,
  parameter int HISTORY_DEPTH = 6,
  parameter int INTERVAL_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  wst_in_if.sink      in_ch,
  wst_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int W = wst_pkg::DIV_W;
  localparam int IB = INTERVAL_BITS;
  localparam int HD = HISTORY_DEPTH;
  localparam int NP = HD - 1;
  localparam int HIW = $clog2(HD + 1);
  localparam int HXW = $clog2(HD);
  localparam logic [IB-1:0] IMAX = {IB{1'b1}};
  localparam longint unsigned TR = TICK_RATE_HZ;
  localparam longint unsigned TWO_TR = 2 * TR;
  // trimmed sum / (NP*256): shift by 8, clamp where the result saturates anyway,
  // then an exact reciprocal multiply for the divide by NP
  localparam int QW = 20;
  localparam longint unsigned QCLAMP = 32768 * NP;
  localparam int RK = QW + $clog2(NP);
  localparam longint unsigned RECIP = ((64'd1 << RK) + NP - 1) / NP;

  localparam logic [3:0] S_IDLE = 4'd0, S_DIST = 4'd1, S_SPD = 4'd2, S_V = 4'd3,
                         S_VW = 4'd4, S_A = 4'd5, S_AMUL = 4'd6, S_AW = 4'd7,
                         S_FIN = 4'd8, S_FINW = 4'd9, S_OUT = 4'd10,
                         S_DW = 4'd11, S_SW = 4'd12, S_AMUL2 = 4'd13;

  // config
  logic [wst_pkg::DIAM_W-1:0] diam_r;
  logic [wst_pkg::TPR_W-1:0]  tpr_r;
  logic [wst_pkg::THR_W-1:0]  thr_r;
  logic cfg_wr;
  logic [1:0] cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[3:2];

  always_comb begin
    case (cfg_idx)
      wst_pkg::REG_DIAM: cfg_prdata = 32'(diam_r);
      wst_pkg::REG_TPR:  cfg_prdata = 32'(tpr_r);
      wst_pkg::REG_THR:  cfg_prdata = 32'(thr_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // tracker state
  logic signed [9:0] integ_r, integ_nxt;
  logic              lvl_r, lvl_nxt;
  logic [IB-1:0]     elap_r, elap_nxt;
  logic [IB-1:0]     last_r, last_nxt;
  logic [IB-1:0]     hist_r [HD], hist_nxt [HD];
  logic [31:0]       cnt_r, cnt_nxt;
  logic              rise_nxt;
  logic signed [9:0] thr_s;

  always_comb begin
    thr_s = signed'({2'b00, thr_r});
    integ_nxt = integ_r;
    lvl_nxt = lvl_r;
    elap_nxt = elap_r;
    last_nxt = last_r;
    cnt_nxt = cnt_r;
    rise_nxt = 1'b0;
    for (int i = 0; i < HD; i++) hist_nxt[i] = hist_r[i];
    if (in_ch.sensor_level && integ_r < thr_s) integ_nxt = integ_r + 10'sd1;
    else if (!in_ch.sensor_level && integ_r > -thr_s) integ_nxt = integ_r - 10'sd1;
    if (integ_nxt >= thr_s && !lvl_r) begin
      for (int i = 1; i < HD; i++) hist_nxt[i] = hist_r[i-1];
      hist_nxt[0] = elap_r;
      last_nxt = elap_r;
      cnt_nxt = cnt_r + 32'd1;
      elap_nxt = '0;
      lvl_nxt = 1'b1;
      rise_nxt = 1'b1;
    end else if (integ_nxt <= -thr_s && lvl_r) begin
      lvl_nxt = 1'b0;
    end
    if (elap_nxt != IMAX) elap_nxt = elap_nxt + 1'b1;
  end

  // sequencer
  logic [3:0]      st_r, st_nxt;
  logic [HIW-1:0]  idx_r, idx_nxt;
  logic [HXW-1:0]  hix, hix1;
  logic            rise_r, rise_r_nxt;
  logic [W-1:0]    v_r [HD];
  logic [W-1:0]    dist_r, spd_r;
  logic signed [W-1:0] sum_r, mn_r, mx_r, a_r;
  logic [W-1:0]    mul_r;
  logic            neg_r;
  logic [IB:0]     hs_r;
  logic [QW-1:0]   qin_r;
  logic            qneg_r;
  wst_pkg::div_req_t dreq;
  logic            ddone;
  logic [W-1:0]    dquo;
  wst_pkg::result_t res_r;
  logic            ovalid_r;
  logic            out_load;

  wst_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quo(dquo));

  logic [W-1:0] dnum;
  logic [IB-1:0] ival;
  logic [IB:0]  hs_c;
  logic signed [W-1:0] diff_c, a_c, tot_c, sat_c;
  logic [W-1:0] mag_c, qmag_c;
  assign hix = idx_r[HXW-1:0];
  assign hix1 = HXW'(idx_r + 1'b1);
  assign dnum = W'(diam_r) * W'(wst_pkg::UM_PER_CI);
  assign ival = (elap_r > last_r) ? elap_r : last_r;
  assign hs_c = {1'b0, hist_r[hix]} + {1'b0, hist_r[hix1]};
  assign diff_c = signed'(v_r[hix]) - signed'(v_r[hix1]);
  assign a_c = neg_r ? -signed'(dquo) : signed'(dquo);
  assign tot_c = sum_r - mn_r - mx_r;
  assign mag_c = tot_c[W-1] ? W'(-tot_c) : W'(tot_c);

  // a finished result waits here only while the previous word is still held
  assign out_load = (st_r == S_OUT) && (!ovalid_r || out_ch.ready);
  assign in_ch.ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    rise_r_nxt = rise_r;
    dreq = '0;
    case (st_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) begin
        st_nxt = S_DIST;
        rise_r_nxt = rise_nxt;
      end
      S_DIST: begin
        dreq.start = 1'b1;
        dreq.num = W'(cnt_r) * dnum;
        dreq.den = W'(tpr_r) * W'(1000000);
        st_nxt = (tpr_r == '0) ? S_OUT : S_DW;
      end
      S_DW: if (ddone) st_nxt = S_SPD;
      S_SPD: begin
        dreq.start = (ival != '0);
        dreq.num = dnum * W'(TR);
        dreq.den = W'(tpr_r) * W'(ival) * W'(1000);
        idx_nxt = '0;
        st_nxt = (ival != '0) ? S_SW : S_V;
      end
      S_SW: if (ddone) st_nxt = S_V;
      S_V: begin
        if (tpr_r < wst_pkg::TPR_W'(wst_pkg::MIN_TPR_ACCEL)) st_nxt = S_OUT;
        else if (idx_r == HIW'(HD)) begin
          idx_nxt = '0;
          st_nxt = S_A;
        end else begin
          dreq.start = (hist_r[hix] != '0);
          dreq.num = dnum * W'(TR) * W'(256);
          dreq.den = W'(tpr_r) * W'(hist_r[hix]) * W'(1000);
          st_nxt = S_VW;
        end
      end
      S_VW: if (ddone || hist_r[hix] == '0) begin
        idx_nxt = idx_r + 1'b1;
        st_nxt = S_V;
      end
      S_A: begin
        if (idx_r == HIW'(NP)) st_nxt = S_FIN;
        else st_nxt = S_AMUL;
      end
      S_AMUL: st_nxt = S_AMUL2;
      S_AMUL2: begin
        dreq.start = 1'b1;
        dreq.num = mul_r;
        dreq.den = W'(hs_r);
        st_nxt = S_AW;
      end
      S_AW: if (ddone) begin
        idx_nxt = idx_r + 1'b1;
        st_nxt = S_A;
      end
      S_FIN: st_nxt = S_FINW;
      S_FINW: st_nxt = S_OUT;
      S_OUT: if (out_load) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    qmag_c = (W'(qin_r) * W'(RECIP)) >> RK;
    if (qneg_r) sat_c = -signed'(qmag_c);
    else if (qmag_c > W'(32767)) sat_c = 64'sd32767;
    else sat_c = signed'(qmag_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diam_r <= wst_pkg::DIAM_W'(2800);
      tpr_r <= wst_pkg::TPR_W'(1);
      thr_r <= wst_pkg::THR_W'(25);
      integ_r <= '0;
      lvl_r <= 1'b0;
      elap_r <= '0;
      last_r <= '0;
      cnt_r <= '0;
      for (int i = 0; i < HD; i++) hist_r[i] <= '0;
      st_r <= S_IDLE;
      idx_r <= '0;
      rise_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          wst_pkg::REG_DIAM: diam_r <= cfg_pwdata[wst_pkg::DIAM_W-1:0];
          wst_pkg::REG_TPR:  tpr_r <= cfg_pwdata[wst_pkg::TPR_W-1:0];
          wst_pkg::REG_THR:  thr_r <= cfg_pwdata[wst_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        integ_r <= integ_nxt;
        lvl_r <= lvl_nxt;
        elap_r <= elap_nxt;
        last_r <= last_nxt;
        cnt_r <= cnt_nxt;
        for (int i = 0; i < HD; i++) hist_r[i] <= hist_nxt[i];
      end
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      rise_r <= rise_r_nxt;
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      S_DIST: begin
        dist_r <= '0;
        spd_r <= '0;
        sum_r <= '0;
        mn_r <= '0;
        mx_r <= '0;
        for (int i = 0; i < HD; i++) v_r[i] <= '0;
      end
      S_DW: if (ddone) dist_r <= (dquo > W'(32'hFFFF_FFFF)) ? W'(32'hFFFF_FFFF) : dquo;
      S_SW: if (ddone) spd_r <= (dquo > W'(16'hFFFF)) ? W'(16'hFFFF) : dquo;
      S_VW: if (ddone) v_r[hix] <= dquo;
      S_A: begin
        hs_r <= hs_c;
        neg_r <= diff_c[W-1];
        a_r <= diff_c;
      end
      S_AMUL: begin
        mul_r <= (W'(hs_r) * W'(100) > W'(TWO_TR)) ?
                 (a_r[W-1] ? W'(-a_r) : W'(a_r)) * W'(TWO_TR) : '0;
        if (hs_r == '0) hs_r <= (IB+1)'(1);
      end
      S_AW: if (ddone) begin
        sum_r <= sum_r + a_c;
        if (idx_r == '0 || a_c < mn_r) mn_r <= a_c;
        if (idx_r == '0 || a_c > mx_r) mx_r <= a_c;
      end
      S_FIN: begin
        qneg_r <= tot_c[W-1];
        qin_r <= ((mag_c >> 8) >= W'(QCLAMP)) ? QW'(QCLAMP) : QW'(mag_c >> 8);
      end
      S_FINW: a_r <= sat_c;
      default: ;
    endcase
    if (out_load) begin
      res_r.pulse_count <= cnt_r;
      res_r.distance_m <= (tpr_r == '0) ? 32'd0 : dist_r[31:0];
      res_r.speed_mm_s <= (tpr_r == '0) ? 16'd0 : spd_r[15:0];
      res_r.accel_mm_s2 <= (tpr_r < wst_pkg::TPR_W'(wst_pkg::MIN_TPR_ACCEL)) ? 16'sd0
                           : a_r[15:0];
      res_r.rising_edge <= rise_r;
      res_r.debounced_level <= lvl_r;
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.pulse_count = res_r.pulse_count;
  assign out_ch.distance_m = res_r.distance_m;
  assign out_ch.speed_mm_s = res_r.speed_mm_s;
  assign out_ch.accel_mm_s2 = res_r.accel_mm_s2;
  assign out_ch.rising_edge = res_r.rising_edge;
  assign out_ch.debounced_level = res_r.debounced_level;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |=> out_ch.valid) else $error("result not posted");
  a_rise_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.rising_edge |-> out_ch.debounced_level)
    else $error("edge without high level");
endmodule

>>> dv/testbench.sv
// Testbench for wheel_speed_sensor_tracker_core: drives random sensor ticks,
// predicts every result word in a scoreboard and checks it field by field.
// Depends on wst_pkg, wst_if and the core RTL.
`timescale 1ns / 1ps

module testbench;
  localparam int TICK_HZ = 10000;
  localparam int HIST = 6;
  localparam int IVL_BITS = 24;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 40000000;

  class speed_scoreboard;
    int unsigned diam, tpr, thr;
    int integ;
    bit lvl_st;
    longint unsigned elapsed, last_ivl;
    longint unsigned hist[HIST];
    bit [31:0] edges;
    wst_pkg::result_t expected_words[$];
    int errors;

    function new();
      diam = 2800; tpr = 1; thr = 25;
      integ = 0; lvl_st = 0; elapsed = 0; last_ivl = 0; edges = 0; errors = 0;
      foreach (hist[i]) hist[i] = 0;
    endfunction

    function longint speed_q8(longint unsigned h);
      if (h == 0 || tpr == 0) return 0;
      return longint'((longint'(diam) * wst_pkg::UM_PER_CI * TICK_HZ * 256) /
                      (longint'(tpr) * h * 1000));
    endfunction

    function longint accel();
      longint sum, mn, mx, a, res;
      longint unsigned hs;
      sum = 0; mn = 0; mx = 0;
      if (tpr < wst_pkg::MIN_TPR_ACCEL) return 0;
      for (int i = 0; i < HIST - 1; i++) begin
        hs = hist[i] + hist[i+1];
        a = 0;
        if (hs * 100 > 2 * TICK_HZ)
          a = ((speed_q8(hist[i]) - speed_q8(hist[i+1])) * (2 * TICK_HZ)) / longint'(hs);
        sum += a;
        if (i == 0 || a < mn) mn = a;
        if (i == 0 || a > mx) mx = a;
      end
      res = (sum - mn - mx) / ((HIST - 1) * 256);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return res;
    endfunction

    function void note_tick(bit lvl);
      wst_pkg::result_t w;
      bit rise;
      longint unsigned ivl, dnum, dist_m, spd;
      longint acc;
      rise = 0; dist_m = 0; spd = 0;
      if (lvl && integ < int'(thr)) integ++;
      else if (!lvl && integ > -int'(thr)) integ--;
      if (integ >= int'(thr) && !lvl_st) begin
        for (int i = HIST - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = elapsed;
        last_ivl = elapsed;
        edges++;
        elapsed = 0;
        lvl_st = 1;
        rise = 1;
      end else if (integ <= -int'(thr) && lvl_st) begin
        lvl_st = 0;
      end
      if (elapsed < (64'd1 << IVL_BITS) - 1) elapsed++;
      ivl = (elapsed > last_ivl) ? elapsed : last_ivl;
      if (tpr != 0) begin
        dnum = longint'(diam) * wst_pkg::UM_PER_CI;
        dist_m = (longint'(edges) * dnum) / (longint'(tpr) * 1000000);
        if (dist_m > 64'hFFFF_FFFF) dist_m = 64'hFFFF_FFFF;
        if (ivl != 0) begin
          spd = (dnum * TICK_HZ) / (longint'(tpr) * ivl * 1000);
          if (spd > 65535) spd = 65535;
        end
      end
      acc = accel();
      w.pulse_count = edges;
      w.distance_m = dist_m[31:0];
      w.speed_mm_s = spd[15:0];
      w.accel_mm_s2 = acc[15:0];
      w.rising_edge = rise;
      w.debounced_level = lvl_st;
      expected_words.push_back(w);
    endfunction

    task report(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_word(wst_pkg::result_t got);
      wst_pkg::result_t want;
      if (expected_words.size() == 0) begin
        report("unexpected word", got.pulse_count, 0);
        return;
      end
      want = expected_words.pop_front();
      if (got.pulse_count !== want.pulse_count)
        report("pulse_count", got.pulse_count, want.pulse_count);
      if (got.distance_m !== want.distance_m)
        report("distance_m", got.distance_m, want.distance_m);
      if (got.speed_mm_s !== want.speed_mm_s)
        report("speed_mm_s", got.speed_mm_s, want.speed_mm_s);
      if (got.accel_mm_s2 !== want.accel_mm_s2)
        report("accel_mm_s2", got.accel_mm_s2, want.accel_mm_s2);
      if (got.rising_edge !== want.rising_edge)
        report("rising_edge", got.rising_edge, want.rising_edge);
      if (got.debounced_level !== want.debounced_level)
        report("debounced_level", got.debounced_level, want.debounced_level);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  wst_in_if in_if();
  wst_out_if out_if();

  speed_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_go = 0;
  bit hold_taken = 0;
  int hold_left = 0;
  longint cycles = 0;

  wheel_speed_sensor_tracker_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: checks words, stalls at random or holds off for a long stretch
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      wst_pkg::result_t got;
      got.pulse_count = out_if.pulse_count;
      got.distance_m = out_if.distance_m;
      got.speed_mm_s = out_if.speed_mm_s;
      got.accel_mm_s2 = out_if.accel_mm_s2;
      got.rising_edge = out_if.rising_edge;
      got.debounced_level = out_if.debounced_level;
      sb.check_word(got);
    end
    if (hold_go && !hold_taken) begin
      hold_taken <= 1;
      hold_left <= 4000;
      out_if.ready <= 0;
    end else if (hold_left > 0) begin
      out_if.ready <= 0;
      hold_left <= hold_left - 1;
    end else begin
      out_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  task write_reg(logic [1:0] idx, int unsigned val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      wst_pkg::REG_DIAM: sb.diam = val & 13'h1FFF;
      wst_pkg::REG_TPR:  sb.tpr = val & 8'hFF;
      wst_pkg::REG_THR:  sb.thr = val & 8'hFF;
      default: ;
    endcase
  endtask

  task drain();
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task configure(int unsigned d, int unsigned t, int unsigned h);
    in_if.valid <= 0;
    drain();
    write_reg(wst_pkg::REG_DIAM, d);
    write_reg(wst_pkg::REG_TPR, t);
    write_reg(wst_pkg::REG_THR, h);
  endtask

  task send_tick(bit lvl);
    if ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_if.valid <= 1;
    in_if.sensor_level <= lvl;
    do @(posedge clk); while (!in_if.ready);
    sb.note_tick(lvl);
  endtask

  // mostly clean level runs of random length, some noisy stretches
  task send_runs(int count, int lo, int hi);
    int n, len;
    bit lvl;
    n = 0;
    lvl = $urandom_range(1);
    while (n < count) begin
      len = $urandom_range(hi, lo);
      lvl = ~lvl;
      for (int k = 0; k < len && n < count; k++) begin
        if ($urandom_range(7) == 0) send_tick($urandom_range(1));
        else send_tick(lvl);
        n++;
      end
    end
  endtask

  initial begin
    in_if.valid <= 0;
    in_if.sensor_level <= 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: fast edges at the extremes, then an unused register index
    configure(6553, wst_pkg::MIN_TPR_ACCEL, 2);
    for (int i = 0; i < 20; i++) send_tick(i[1]);
    configure(0, 1, 1);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_tick(i[0]);

    idle_pct = 0; stall_pct = 0;
    configure(6553, 255, 1);
    send_runs(300, 1, 40);

    idle_pct = 64; stall_pct = 0;
    configure(0, 6, 3);
    send_runs(150, 1, 20);

    idle_pct = 0; stall_pct = 64;
    configure(2800, 8, 2);
    @(posedge clk);
    hold_go <= 1;
    send_runs(350, 60, 150);

    idle_pct = 21; stall_pct = 21;
    configure(1234, 0, 4);
    send_runs(150, 1, 30);

    idle_pct = 0; stall_pct = 0;
    configure(6553, 6, 0);
    send_runs(150, 1, 10);

    idle_pct = 64; stall_pct = 0;
    configure(1, 255, 255);
    send_runs(300, 250, 320);

    idle_pct = 21; stall_pct = 21;
    configure(5000, 12, 5);
    send_runs(150, 40, 140);
    in_if.valid <= 0;
    drain();
    send_runs(150, 40, 140);

    in_if.valid <= 0;
    drain();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/wst_pkg.sv
rtl/core/wst_if.sv
rtl/core/wst_div.sv
rtl/core/wheel_speed_sensor_tracker_core.sv
dv/testbench.sv
